FILE: sv/tpm_rsa_public_area_parser_core_macros.svh
// assertion helpers for the rsa public area parser
`ifndef TPM_RSA_PUBLIC_AREA_PARSER_CORE_MACROS_SVH
`define TPM_RSA_PUBLIC_AREA_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TRPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsa parser check failed");

// next-cycle implication, sampled on clk, off while in reset
`define TRPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsa parser check failed");

`endif

FILE: sv/tpmrsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpmrsa_pkg;

	localparam int unsigned POLICY_MAX_BYTES = 64;
	localparam int unsigned UNIQUE_MAX_BYTES = 512;

	// tcg algorithm ids
	localparam logic [31:0] ALG_RSA  = 32'h0000_0001;
	localparam logic [31:0] ALG_AES  = 32'h0000_0006;
	localparam logic [31:0] ALG_NULL = 32'h0000_0010;

	// field ids, also used as parse phases
	localparam logic [3:0] FID_TYPE        = 4'd0;
	localparam logic [3:0] FID_NAME_ALG    = 4'd1;
	localparam logic [3:0] FID_ATTRIBUTES  = 4'd2;
	localparam logic [3:0] FID_POLICY_LEN  = 4'd3;
	localparam logic [3:0] FID_POLICY_BYTE = 4'd4;
	localparam logic [3:0] FID_SYM_ALG     = 4'd5;
	localparam logic [3:0] FID_SYM_BITS    = 4'd6;
	localparam logic [3:0] FID_SYM_MODE    = 4'd7;
	localparam logic [3:0] FID_SCHEME      = 4'd8;
	localparam logic [3:0] FID_KEY_BITS    = 4'd9;
	localparam logic [3:0] FID_EXPONENT    = 4'd10;
	localparam logic [3:0] FID_UNIQUE_LEN  = 4'd11;
	localparam logic [3:0] FID_UNIQUE_BYTE = 4'd12;
	localparam logic [3:0] FID_NONE        = 4'd13;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_INSUFF = 3'd1;
	localparam logic [2:0] ST_TYPE   = 3'd2;
	localparam logic [2:0] ST_HASH   = 3'd3;
	localparam logic [2:0] ST_SIZE   = 3'd4;
	localparam logic [2:0] ST_SYM    = 3'd5;
	localparam logic [2:0] ST_SCHEME = 3'd6;
	localparam logic [2:0] ST_VALUE  = 3'd7;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_C = 2'd2;

	localparam logic [15:0] HASH_A_RESET = 16'd11;
	localparam logic [15:0] HASH_B_RESET = 16'd4;
	localparam logic [15:0] HASH_C_RESET = 16'd12;

	typedef struct packed {
		logic [3:0]  parse_phase;
		logic [1:0]  byte_in_field;
		logic [31:0] value_accumulator;
		logic [15:0] payload_remaining;
		logic [11:0] bytes_consumed;
		logic        type_is_rsa;
		logic        draining;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '0;

	typedef struct packed {
		logic [15:0] id_a;
		logic [15:0] id_b;
		logic [15:0] id_c;
	} hash_cfg_t;

	typedef struct packed {
		logic [3:0]  field_id;
		logic [31:0] field_value;
		logic [15:0] byte_offset;
		logic [2:0]  status;
		logic        done_res;
		logic [11:0] used_bytes;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/tpm_rsa_public_area_parser_core.sv
// rsa public area parser: one byte per item, big-endian fields
// a byte passes the input register stage and then the result register stage before its result is presented
// throughput: one byte per cycle, limited only by the result register handshake
// reset: arst_n clears parse state, pipeline valids and restores hash ids 11, 4, 12
// bytes that are no payload byte, finish no field and carry no error give no result item
`timescale 1ns / 1ps
`default_nettype none
`include "tpm_rsa_public_area_parser_core_macros.svh"
module tpm_rsa_public_area_parser_core import tpmrsa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	// byte input channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 in_last,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [3:0]                field_id,
	output logic [31:0]               field_value,
	output logic [15:0]               byte_offset,
	output logic [2:0]                status,
	output logic                      done_res,
	output logic [11:0]               used_bytes
);

	hash_cfg_t    hash_cfg;
	parse_state_t state_q;
	parse_state_t st_next;
	result_t      step_res;
	logic         step_valid;

	// input register stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	// result register stage
	logic         valid_s2;
	result_t      res_s2;

	logic         s2_free;
	logic         advance;

	tpmrsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hash_cfg  (hash_cfg)
	);

	// all per-byte decisions: shift, compares and next phase
	tpmrsa_step u_step (
		.st        (state_q),
		.hash_cfg  (hash_cfg),
		.in_byte   (byte_s1),
		.in_last   (last_s1),
		.st_next   (st_next),
		.res_valid (step_valid),
		.res       (step_res)
	);

	// result register can load when empty or being drained this cycle
	assign s2_free  = !valid_s2 || out_ready;
	// the byte in stage one is consumed whenever the result side has room
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// parser state moves once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && step_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid   = valid_s2;
	assign field_id    = res_s2.field_id;
	assign field_value = res_s2.field_value;
	assign byte_offset = res_s2.byte_offset;
	assign status      = res_s2.status;
	assign done_res    = res_s2.done_res;
	assign used_bytes  = res_s2.used_bytes;

	// byte count is only reported on a clean finish
	`TRPA_ASSERT_NOW(a_used_only_ok, out_valid && (!done_res || status != ST_OK), used_bytes == 12'd0)
	// a result without a field is always an early buffer end
	`TRPA_ASSERT_NOW(a_none_is_insuff, out_valid && field_id == FID_NONE, done_res && status == ST_INSUFF)
	// offsets belong to payload bytes only
	`TRPA_ASSERT_NOW(a_offset_payload, out_valid && field_id != FID_POLICY_BYTE && field_id != FID_UNIQUE_BYTE, byte_offset == 16'd0)
	// a consumed last byte always leaves the parser restarted
	`TRPA_ASSERT_NEXT(a_last_restarts, advance && last_s1, state_q == STATE_RESET || !step_valid || !step_res.done_res)

endmodule
`default_nettype wire

FILE: sv/tpmrsa_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module tpmrsa_cfg import tpmrsa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	output hash_cfg_t                 hash_cfg
);

	hash_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign hash_cfg  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.id_a <= HASH_A_RESET;
			cfg_q.id_b <= HASH_B_RESET;
			cfg_q.id_c <= HASH_C_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HASH_A: cfg_q.id_a <= cfg_data;
				CFG_HASH_B: cfg_q.id_b <= cfg_data;
				CFG_HASH_C: cfg_q.id_c <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/tpmrsa_step.sv
`timescale 1ns / 1ps
`default_nettype none
module tpmrsa_step import tpmrsa_pkg::*; (
	input  wire parse_state_t st,
	input  wire hash_cfg_t    hash_cfg,
	input  wire logic [7:0]   in_byte,
	input  wire logic         in_last,
	output parse_state_t      st_next,
	output logic              res_valid,
	output result_t           res
);

	logic [31:0] acc_shift;
	logic [1:0]  bif_inc;
	logic [15:0] rem_dec;
	logic        field_len4;
	logic        complete;
	logic        is_payload;
	logic        have;
	logic        finished;
	logic        bad_phase;
	logic        done;
	logic [2:0]  err;
	logic        hash_ok;

	assign acc_shift  = {st.value_accumulator[23:0], in_byte};
	assign bif_inc    = st.byte_in_field + 2'd1;
	assign rem_dec    = st.payload_remaining - 16'd1;
	assign field_len4 = (st.parse_phase == FID_ATTRIBUTES) || (st.parse_phase == FID_EXPONENT);
	// a field completes on its second or fourth byte
	assign complete   = (bif_inc == 2'd0) || (!field_len4 && (bif_inc >= 2'd2));
	assign is_payload = (st.parse_phase == FID_POLICY_BYTE) ||
		(st.parse_phase == FID_UNIQUE_BYTE);
	// zero id marks an unused slot
	assign hash_ok = (acc_shift != 32'd0) &&
		((acc_shift == {16'd0, hash_cfg.id_a}) ||
		 (acc_shift == {16'd0, hash_cfg.id_b}) ||
		 (acc_shift == {16'd0, hash_cfg.id_c}));

	always_comb begin
		st_next        = st;
		res            = '0;
		res.field_id   = FID_NONE;
		have           = 1'b0;
		finished       = 1'b0;
		bad_phase      = 1'b0;
		done           = 1'b0;
		err            = ST_OK;
		res_valid      = 1'b0;
		if (st.draining) begin
			if (in_last) begin
				st_next = STATE_RESET;
			end
		end else begin
			st_next.bytes_consumed = st.bytes_consumed + 12'd1;
			if (is_payload) begin
				have                      = 1'b1;
				res.field_id              = st.parse_phase;
				res.field_value           = {24'd0, in_byte};
				res.byte_offset           = st.value_accumulator[15:0] - st.payload_remaining;
				st_next.payload_remaining = rem_dec;
				if (rem_dec == 16'd0) begin
					st_next.value_accumulator = 32'd0;
					if (st.parse_phase == FID_POLICY_BYTE) begin
						st_next.parse_phase = FID_SYM_ALG;
					end else begin
						finished = 1'b1;
					end
				end
			end else if (st.parse_phase > FID_UNIQUE_BYTE) begin
				bad_phase = 1'b1;
				st_next   = STATE_RESET;
			end else begin
				st_next.value_accumulator = acc_shift;
				st_next.byte_in_field     = bif_inc;
				if (complete) begin
					st_next.byte_in_field     = 2'd0;
					st_next.value_accumulator = 32'd0;
					have                      = 1'b1;
					res.field_id              = st.parse_phase;
					res.field_value           = acc_shift;
					case (st.parse_phase)
						FID_TYPE: begin
							st_next.type_is_rsa = (acc_shift == ALG_RSA);
							st_next.parse_phase = FID_NAME_ALG;
						end
						FID_NAME_ALG: begin
							if (!st.type_is_rsa) begin
								err = ST_TYPE;
							end else if (!hash_ok) begin
								err = ST_HASH;
							end
							st_next.parse_phase = FID_ATTRIBUTES;
						end
						FID_ATTRIBUTES: st_next.parse_phase = FID_POLICY_LEN;
						FID_POLICY_LEN: begin
							if (acc_shift > 32'(POLICY_MAX_BYTES)) begin
								err = ST_SIZE;
							end else if (acc_shift == 32'd0) begin
								st_next.parse_phase = FID_SYM_ALG;
							end else begin
								st_next.payload_remaining = acc_shift[15:0];
								st_next.value_accumulator = acc_shift;
								st_next.parse_phase       = FID_POLICY_BYTE;
							end
						end
						FID_SYM_ALG: begin
							if (acc_shift == ALG_NULL) begin
								st_next.parse_phase = FID_SCHEME;
							end else if (acc_shift != ALG_AES) begin
								err = ST_SYM;
							end else begin
								st_next.parse_phase = FID_SYM_BITS;
							end
						end
						FID_SYM_BITS: st_next.parse_phase = FID_SYM_MODE;
						FID_SYM_MODE: st_next.parse_phase = FID_SCHEME;
						FID_SCHEME: begin
							if (acc_shift != ALG_NULL) begin
								err = ST_SCHEME;
							end
							st_next.parse_phase = FID_KEY_BITS;
						end
						FID_KEY_BITS: st_next.parse_phase = FID_EXPONENT;
						FID_EXPONENT: begin
							if ((acc_shift != 32'd0) &&
								((acc_shift <= 32'd2) || !acc_shift[0])) begin
								err = ST_VALUE;
							end
							st_next.parse_phase = FID_UNIQUE_LEN;
						end
						FID_UNIQUE_LEN: begin
							if (acc_shift > 32'(UNIQUE_MAX_BYTES)) begin
								err = ST_SIZE;
							end else if (acc_shift == 32'd0) begin
								finished = 1'b1;
							end else begin
								st_next.payload_remaining = acc_shift[15:0];
								st_next.value_accumulator = acc_shift;
								st_next.parse_phase       = FID_UNIQUE_BYTE;
							end
						end
						default: ;
					endcase
				end
			end

			if (!bad_phase) begin
				// a field error outranks running out of buffer
				if (err != ST_OK) begin
					res.status = err;
					done       = 1'b1;
				end else if (finished) begin
					done           = 1'b1;
					res.used_bytes = st_next.bytes_consumed;
				end else if (in_last) begin
					res.status = ST_INSUFF;
					done       = 1'b1;
				end
				res.done_res = done;
				res_valid    = have || done;
				if (done) begin
					if (in_last) begin
						st_next = STATE_RESET;
					end else begin
						st_next.draining = 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire
